@@ hdl/ddos_pkg.sv @@
package ddos_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int TBL_LEN = 24;
  localparam int CORDIC_ITERS = (CORDIC_STEPS < TBL_LEN) ? CORDIC_STEPS : TBL_LEN;
  localparam int CNT_W = (CORDIC_ITERS > 1) ? $clog2(CORDIC_ITERS) : 1;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int CW = 60;
  localparam int ZW = 34;
  localparam int MW = 34;
  localparam int PW = 2 * MW;

  localparam longint Q30_PI = 64'sd3373259426;
  localparam longint Q30_HALF_PI = 64'sd1686629713;
  localparam longint Q30_TWO_PI = 64'sd6746518852;
  localparam longint CORDIC_GAIN = 64'sd652032874;
  localparam longint RATIO_Q16 = 64'sd107479;
  localparam longint STEER_GAIN = 64'sd25478;
  localparam longint ONE_Q32 = 64'sd4294967296;
  localparam logic [3:0] MOD_TOP = 4'd12;

  localparam logic [1:0] REQ_LEFT = 2'd0;
  localparam logic [1:0] REQ_RIGHT = 2'd1;
  localparam logic [1:0] REQ_CMD = 2'd2;

  typedef enum logic [1:0] {K_LEFT, K_UPDATE, K_CMD, K_NOP} req_kind_e;

  typedef enum logic [2:0] {
    REG_LEFT_SCALE, REG_RIGHT_SCALE, REG_INV_WB, REG_GOAL_X,
    REG_GOAL_Y, REG_FAR_SPEED, REG_NEAR_SPEED, REG_STEER_LIMIT
  } cfg_reg_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_UL, ST_UR, ST_UH, ST_UHD, ST_UMOD, ST_UFOLD, ST_UCOR,
    ST_UMC, ST_UMS, ST_UPY, ST_UDX, ST_UDY, ST_UD2,
    ST_CY, ST_CCOR, ST_CST, ST_CFIN, ST_OUT
  } back_st_e;

  typedef struct packed {
    req_kind_e          kind;
    logic signed [31:0] rate;
    logic signed [31:0] speed;
    logic signed [31:0] tick;
  } item_t;

  typedef struct packed {
    logic signed [31:0] accel;
    logic signed [15:0] steering;
    logic signed [31:0] heading;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_x;
  } result_t;

  typedef struct packed {
    logic                 start;
    logic                 vector;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_req_t;

  typedef struct packed {
    logic                 done;
    logic                 busy;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_rsp_t;

  function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] idx);
    logic signed [ZW-1:0] a;
    case (idx)
      5'd0: a = 34'sd843314857;
      5'd1: a = 34'sd497837829;
      5'd2: a = 34'sd263043837;
      5'd3: a = 34'sd133525159;
      5'd4: a = 34'sd67021687;
      5'd5: a = 34'sd33543516;
      5'd6: a = 34'sd16775851;
      5'd7: a = 34'sd8388437;
      5'd8: a = 34'sd4194283;
      5'd9: a = 34'sd2097149;
      5'd10: a = 34'sd1048576;
      5'd11: a = 34'sd524288;
      5'd12: a = 34'sd262144;
      5'd13: a = 34'sd131072;
      5'd14: a = 34'sd65536;
      5'd15: a = 34'sd32768;
      5'd16: a = 34'sd16384;
      5'd17: a = 34'sd8192;
      5'd18: a = 34'sd4096;
      5'd19: a = 34'sd2048;
      5'd20: a = 34'sd1024;
      5'd21: a = 34'sd512;
      5'd22: a = 34'sd256;
      5'd23: a = 34'sd128;
      default: a = '0;
    endcase
    return a;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [PW-1:0] v);
    logic signed [31:0] r;
    if (v > 68'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -68'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [PW-1:0] rnd_sh(input logic signed [PW-1:0] v,
                                                  input logic [4:0] s);
    logic signed [PW-1:0] h;
    h = 68'sd1 <<< (s - 5'd1);
    return (v + h) >>> s;
  endfunction

endpackage

@@ hdl/ddos_queue.sv @@
module ddos_queue
  import ddos_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t din_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t dout_o
);

  item_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0]  wr_q, rd_q;
  logic [QCNT_W-1:0]  cnt_q;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign dout_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= din_i;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QDEPTH)) else $error("queue count over depth");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("pop from empty queue");

endmodule

@@ hdl/ddos_cordic.sv @@
module ddos_cordic
  import ddos_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cordic_req_t req_i,
  output cordic_rsp_t rsp_o
);

  logic                 busy_q, done_q, vec_q;
  logic [CNT_W-1:0]     i_q;
  logic signed [CW-1:0] x_q, y_q, xs, ys;
  logic signed [ZW-1:0] z_q, at;
  logic                 pos_dir;

  always_comb begin
    xs = x_q >>> i_q;
    ys = y_q >>> i_q;
    at = atan_q30(5'(i_q));
    pos_dir = vec_q ? !(y_q > 0) : (z_q >= 0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        i_q    <= '0;
      end else if (busy_q) begin
        if (i_q == CNT_W'(CORDIC_ITERS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          i_q <= i_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      x_q   <= req_i.x;
      y_q   <= req_i.y;
      z_q   <= req_i.z;
      vec_q <= req_i.vector;
    end else if (busy_q) begin
      if (pos_dir) begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + at;
      end
    end
  end

  assign rsp_o = '{done: done_q, busy: busy_q, x: x_q, y: y_q, z: z_q};

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q) else $error("cordic started while busy");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q) && !busy_q) else $error("cordic done without run");

endmodule

@@ hdl/ddos_back.sv @@
module ddos_back
  import ddos_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        q_valid_i,
  input  item_t       q_item_i,
  output logic        q_pop_o,
  output cordic_req_t cor_req_o,
  input  cordic_rsp_t cor_rsp_i,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output result_t     res_o
);

  back_st_e state_q, state_d;

  logic [23:0]        lscale_q, rscale_q;
  logic [19:0]        invwb_q;
  logic signed [31:0] goal_x_q, goal_y_q;
  logic [30:0]        far_q, near_q;
  logic [14:0]        lim_q;

  logic signed [31:0] left_raw_q, pl_q, pr_q, pos_x_q, pos_y_q, heading_q, accel_q;
  logic signed [15:0] steer_q;

  item_t                itm_q;
  logic signed [31:0]   ld_q, rd_q;
  logic signed [32:0]   mean_q;
  logic [45:0]          r_q;
  logic [3:0]           k_q;
  logic                 neg_q, flip_q;
  logic signed [ZW-1:0] c_q, s_q, ang_q;
  logic signed [PW-1:0] mp_q, sq_q;
  logic signed [MW-1:0] ma, mb;

  logic                 out_valid_q;
  result_t              out_q;
  logic                 out_load;

  logic signed [31:0]   ld_new, rd_new, h_new, px_new, py_new;
  logic signed [33:0]   msum;
  logic signed [45:0]   hq;
  logic [45:0]          tp_k;
  logic signed [34:0]   z0, z1;
  logic signed [ZW-1:0] z2;
  logic                 flip_d;
  logic signed [32:0]   dx, dy, spd33;
  logic                 far_axis;
  logic signed [PW-1:0] d2, st_full, lim_s;
  logic signed [CW-1:0] vx0, vy0;
  logic signed [15:0]   st_new;

  always_comb begin
    ld_new = sat32(rnd_sh(mp_q, 5'd8));
    rd_new = sat32(rnd_sh(mp_q, 5'd8));
    msum = 34'(ld_q) - 34'(pl_q) + 34'(rd_new) - 34'(pr_q);
    h_new = sat32(rnd_sh(mp_q, 5'd16));
    hq = {h_new, 14'b0};
    tp_k = 46'(Q30_TWO_PI) << k_q;
    z0 = neg_q ? -$signed({2'b0, r_q[32:0]}) : $signed({2'b0, r_q[32:0]});
    z1 = z0;
    if (z1 > 35'(Q30_PI)) begin
      z1 = z1 - 35'(Q30_TWO_PI);
    end
    if (z1 < -35'(Q30_PI)) begin
      z1 = z1 + 35'(Q30_TWO_PI);
    end
    flip_d = 1'b0;
    if (z1 > 35'(Q30_HALF_PI)) begin
      z1 = z1 - 35'(Q30_PI);
      flip_d = 1'b1;
    end else if (z1 < -35'(Q30_HALF_PI)) begin
      z1 = z1 + 35'(Q30_PI);
      flip_d = 1'b1;
    end
    z2 = ZW'(z1);
    px_new = sat32(PW'(pos_x_q) + rnd_sh(mp_q, 5'd30));
    py_new = sat32(PW'(pos_y_q) + rnd_sh(mp_q, 5'd30));
    dx = 33'(goal_x_q) - 33'(pos_x_q);
    dy = 33'(goal_y_q) - 33'(pos_y_q);
    far_axis = (dx > 33'sd65536) || (dx < -33'sd65536) ||
               (dy > 33'sd65536) || (dy < -33'sd65536);
    d2 = sq_q + mp_q;
    spd33 = 33'(itm_q.speed);
    if (spd33 < 0) begin
      spd33 = -spd33;
    end
    vx0 = CW'(spd33) <<< 24;
    vy0 = CW'(mp_q) <<< 8;
    if (itm_q.speed < 0) begin
      vy0 = -vy0;
    end
    st_full = rnd_sh(mp_q, 5'd30);
    lim_s = $signed({{(PW-15){1'b0}}, lim_q});
    if (st_full > lim_s) begin
      st_full = lim_s;
    end
    if (st_full < -lim_s) begin
      st_full = -lim_s;
    end
    st_new = st_full[15:0];
  end

  always_comb begin
    state_d = state_q;
    ma = '0;
    mb = '0;
    q_pop_o = 1'b0;
    cor_req_o = '0;
    out_load = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          case (q_item_i.kind)
            K_UPDATE: begin
              ma = MW'(left_raw_q);
              mb = $signed({10'b0, lscale_q});
              state_d = ST_UL;
            end
            K_CMD: begin
              ma = MW'(q_item_i.rate);
              mb = MW'(RATIO_Q16);
              if (q_item_i.rate == '0 || q_item_i.speed == '0) begin
                state_d = ST_CST;
              end else begin
                state_d = ST_CY;
              end
            end
            default: state_d = ST_OUT;
          endcase
        end
      end
      ST_UL: begin
        ma = MW'(itm_q.tick);
        mb = $signed({10'b0, rscale_q});
        state_d = ST_UR;
      end
      ST_UR: state_d = ST_UH;
      ST_UH: begin
        ma = MW'(rd_q) - MW'(ld_q);
        mb = $signed({14'b0, invwb_q});
        state_d = ST_UHD;
      end
      ST_UHD: state_d = ST_UMOD;
      ST_UMOD: begin
        if (k_q == '0) begin
          state_d = ST_UFOLD;
        end
      end
      ST_UFOLD: begin
        cor_req_o = '{start: 1'b1, vector: 1'b0, x: CW'(CORDIC_GAIN), y: '0, z: z2};
        state_d = ST_UCOR;
      end
      ST_UCOR: begin
        if (cor_rsp_i.done) begin
          state_d = ST_UMC;
        end
      end
      ST_UMC: begin
        ma = MW'(mean_q);
        mb = c_q;
        state_d = ST_UMS;
      end
      ST_UMS: begin
        ma = MW'(mean_q);
        mb = s_q;
        state_d = ST_UPY;
      end
      ST_UPY: state_d = ST_UDX;
      ST_UDX: begin
        ma = MW'(dx);
        mb = MW'(dx);
        state_d = far_axis ? ST_OUT : ST_UDY;
      end
      ST_UDY: begin
        ma = MW'(dy);
        mb = MW'(dy);
        state_d = ST_UD2;
      end
      ST_UD2: state_d = ST_OUT;
      ST_CY: begin
        cor_req_o = '{start: 1'b1, vector: 1'b1, x: vx0, y: vy0, z: '0};
        state_d = ST_CCOR;
      end
      ST_CCOR: begin
        if (cor_rsp_i.done) begin
          state_d = ST_CST;
        end
      end
      ST_CST: begin
        ma = ang_q;
        mb = MW'(STEER_GAIN);
        state_d = ST_CFIN;
      end
      ST_CFIN: state_d = ST_OUT;
      ST_OUT: begin
        if (!out_valid_q || res_ready_i) begin
          out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lscale_q <= 24'd77020;
      rscale_q <= 24'd59388;
      invwb_q  <= 20'd66873;
      goal_x_q <= '0;
      goal_y_q <= '0;
      far_q    <= 31'd39322;
      near_q   <= 31'd26214;
      lim_q    <= 15'd20000;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_LEFT_SCALE:  lscale_q <= cfg_data_i[23:0];
        REG_RIGHT_SCALE: rscale_q <= cfg_data_i[23:0];
        REG_INV_WB:      invwb_q <= cfg_data_i[19:0];
        REG_GOAL_X:      goal_x_q <= cfg_data_i;
        REG_GOAL_Y:      goal_y_q <= cfg_data_i;
        REG_FAR_SPEED:   far_q <= cfg_data_i[30:0];
        REG_NEAR_SPEED:  near_q <= cfg_data_i[30:0];
        REG_STEER_LIMIT: lim_q <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_raw_q  <= '0;
      pl_q        <= '0;
      pr_q        <= '0;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      heading_q   <= '0;
      steer_q     <= '0;
      accel_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (q_valid_i && q_item_i.kind == K_LEFT) begin
            left_raw_q <= q_item_i.tick;
          end
          if (q_valid_i && q_item_i.kind == K_CMD) begin
            accel_q <= q_item_i.speed;
          end
        end
        ST_UR: begin
          pl_q <= ld_q;
          pr_q <= rd_new;
        end
        ST_UHD: heading_q <= h_new;
        ST_UMS: pos_x_q <= px_new;
        ST_UPY: pos_y_q <= py_new;
        ST_UDX: begin
          if (far_axis) begin
            accel_q <= {1'b0, far_q};
          end
        end
        ST_UD2: begin
          if (d2 > PW'(ONE_Q32)) begin
            accel_q <= {1'b0, far_q};
          end else if (d2 > 0 && d2 < PW'(ONE_Q32)) begin
            accel_q <= {1'b0, near_q};
          end
        end
        ST_CFIN: steer_q <= st_new;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    mp_q <= ma * mb;
    case (state_q)
      ST_IDLE: begin
        itm_q <= q_item_i;
        if (q_item_i.rate == '0) begin
          ang_q <= '0;
        end else if (q_item_i.rate > 0) begin
          ang_q <= ZW'(Q30_HALF_PI);
        end else begin
          ang_q <= -ZW'(Q30_HALF_PI);
        end
      end
      ST_UL: ld_q <= ld_new;
      ST_UR: begin
        rd_q   <= rd_new;
        mean_q <= 33'(msum >>> 1);
      end
      ST_UHD: begin
        neg_q <= h_new < 0;
        r_q   <= (hq < 0) ? 46'(-hq) : 46'(hq);
        k_q   <= MOD_TOP;
      end
      ST_UMOD: begin
        if (r_q >= tp_k) begin
          r_q <= r_q - tp_k;
        end
        if (k_q != '0) begin
          k_q <= k_q - 1'b1;
        end
      end
      ST_UFOLD: flip_q <= flip_d;
      ST_UCOR: begin
        c_q <= flip_q ? -ZW'(cor_rsp_i.x) : ZW'(cor_rsp_i.x);
        s_q <= flip_q ? -ZW'(cor_rsp_i.y) : ZW'(cor_rsp_i.y);
      end
      ST_UDY: sq_q <= mp_q;
      ST_CCOR: ang_q <= cor_rsp_i.z;
      ST_OUT: begin
        if (out_load) begin
          out_q <= '{accel: accel_q, steering: steer_q, heading: heading_q,
                     pos_y: pos_y_q, pos_x: pos_x_q};
        end
      end
      default: ;
    endcase
  end

  assign res_valid_o = out_valid_q;
  assign res_o = out_q;

  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_OUT)) else $error("result without finish");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> !cor_rsp_i.busy) else $error("new item while cordic runs");

endmodule

@@ hdl/diff_drive_odometry_steer_unit.sv @@
// channel   dir  handshake                    payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tuser req_type, tdata tick/speed/rate
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata pos_x/pos_y/heading/steering/accel
// cfg       in   cfg_we_i (no wait)           cfg_idx_i, cfg_data_i
// left and unknown beats go straight to the output state; command beats with a nonzero
// rate and speed and all update beats run the iterative cordic (one step per cycle),
// and update beats also run the 13-step heading range reduction before it
// a two-entry queue takes input beats while the sequencer works or a result waits
// reset is asynchronous, active low; registers return to their defaults
// a stalled output holds its beat; the sequencer waits only to load the output register
module diff_drive_odometry_steer_unit
  import ddos_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,  // tick_count, linear_speed, turn_rate
  input  logic [1:0]   s_axis_tuser,  // req_type
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [143:0] m_axis_tdata,  // pos_x_out, pos_y_out, heading_out, steering_out, accel_out
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i
);

  item_t       in_item, q_item;
  req_kind_e   kind;
  logic        q_full, q_valid, q_pop, push;
  cordic_req_t cor_req;
  cordic_rsp_t cor_rsp;
  result_t     res;

  always_comb begin
    case (s_axis_tuser)
      REQ_LEFT:  kind = K_LEFT;
      REQ_RIGHT: kind = K_UPDATE;
      REQ_CMD:   kind = K_CMD;
      default:   kind = K_NOP;
    endcase
    in_item = '{kind: kind, rate: s_axis_tdata[95:64], speed: s_axis_tdata[63:32],
                tick: s_axis_tdata[31:0]};
  end

  assign s_axis_tready = !q_full;
  assign push = s_axis_tvalid && !q_full;

  ddos_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .din_i   (in_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .dout_o  (q_item)
  );

  ddos_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (cor_req),
    .rsp_o  (cor_rsp)
  );

  ddos_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .cor_req_o   (cor_req),
    .cor_rsp_i   (cor_rsp),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = res;

endmodule
